/* rtl/sync_checksum_frame_parser_macros.svh */
// Assertion macros for the sync checksum frame parser checker.
// No dependencies; included by the checker file.
`ifndef SYNC_CHECKSUM_FRAME_PARSER_MACROS_SVH
`define SYNC_CHECKSUM_FRAME_PARSER_MACROS_SVH

// Property checked while out of reset.
`define SCP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included.
`define SCP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* rtl/scp_pkg.sv */
// Shared types and constants for the sync checksum frame parser.
// No dependencies.
package scp_pkg;

    typedef enum logic [3:0] {
        PH_SYNC_A,
        PH_SYNC_B,
        PH_FLAG,
        PH_MARKER,
        PH_LEN,
        PH_HEADER,
        PH_BODY,
        PH_CHECK,
        PH_END_A,
        PH_END_B
    } t_phase;

    localparam logic [2:0] EV_NONE    = 3'd0;
    localparam logic [2:0] EV_STORED  = 3'd1;
    localparam logic [2:0] EV_GOOD    = 3'd2;
    localparam logic [2:0] EV_HDR_BAD = 3'd3;
    localparam logic [2:0] EV_SUM_BAD = 3'd4;
    localparam logic [2:0] EV_END_BAD = 3'd5;

    localparam logic [2:0] CFG_START_SYNC_A = 3'd0;
    localparam logic [2:0] CFG_START_SYNC_B = 3'd1;
    localparam logic [2:0] CFG_END_SYNC_B   = 3'd2;
    localparam logic [2:0] CFG_MARKER_VALUE = 3'd3;
    localparam logic [2:0] CFG_LENGTH_BIAS  = 3'd4;
    localparam logic [2:0] CFG_LENGTH_LIMIT = 3'd5;

    localparam logic [7:0] RST_MARKER_VALUE = 8'd64;
    localparam logic [7:0] RST_LENGTH_BIAS  = 8'd11;
    localparam logic [7:0] RST_LENGTH_LIMIT = 8'd255;

    localparam logic [8:0] CMD_A_POS       = 9'd13;
    localparam logic [8:0] CMD_B_POS       = 9'd14;
    localparam logic [8:0] HEADER_LAST_POS = 9'd15;

    typedef struct packed {
        logic [7:0] start_sync_a;
        logic [7:0] start_sync_b;
        logic [7:0] end_sync_b;
        logic [7:0] marker_value;
        logic [7:0] length_bias;
        logic [7:0] length_limit;
    } t_cfg;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] byte_value;
        logic [8:0] byte_position;
        logic [7:0] command_a;
        logic [7:0] command_b;
        logic [8:0] frame_length;
    } t_result;

endpackage

/* rtl/sync_checksum_frame_parser.sv */
// Sync checksum frame parser: receive byte channel in, one event per byte out.
// Channels: i_in_valid/o_in_ready carry i_rx_byte; o_out_valid/i_out_ready
// carry the event fields. A transfer happens when valid and ready are high.
// Config: i_cfg_we writes i_cfg_data into register i_cfg_idx (0..5) at once.
// Every accepted byte gives exactly one event, registered in the result
// register or the skid entry. One byte per cycle while o_in_ready is high;
// the phase and checksum update is a single add and compare per byte.
// A result register plus one skid entry sit on the output, so a byte is
// still taken while one result waits; with both full o_in_ready drops
// until the receiver takes a result.
// Synchronous active-low reset returns the walker to waiting for the first
// start byte, empties the output stages and loads the register defaults
// (marker 64, length bias 11, length limit 255, syncs 0). Command bytes of
// the frame are kept across an aborted frame, as the walker only clears
// them at reset.
// Depends on scp_pkg, scp_cfg_regs, scp_walker, scp_out_stage.
module sync_checksum_frame_parser
    import scp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [2:0] o_event_res,
    output logic [7:0] o_byte_value,
    output logic [8:0] o_byte_position,
    output logic [7:0] o_command_a,
    output logic [7:0] o_command_b,
    output logic [8:0] o_frame_length
);

    t_cfg    cfg;
    t_result step_res;
    t_result out_res;
    logic    accept;

    assign accept = i_in_valid & o_in_ready;

    scp_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    scp_walker u_walker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_rx_byte (i_rx_byte),
        .i_cfg     (cfg),
        .o_result  (step_res)
    );

    scp_out_stage u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_result    (step_res),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result    (out_res)
    );

    assign o_event_res     = out_res.event_res;
    assign o_byte_value    = out_res.byte_value;
    assign o_byte_position = out_res.byte_position;
    assign o_command_a     = out_res.command_a;
    assign o_command_b     = out_res.command_b;
    assign o_frame_length  = out_res.frame_length;

endmodule

/* rtl/scp_cfg_regs.sv */
// Configuration register file for the frame parser.
// Depends on scp_pkg.
module scp_cfg_regs
    import scp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [2:0] i_cfg_idx,
    input  logic [7:0] i_cfg_data,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_sync_a <= '0;
            r_cfg.start_sync_b <= '0;
            r_cfg.end_sync_b   <= '0;
            r_cfg.marker_value <= RST_MARKER_VALUE;
            r_cfg.length_bias  <= RST_LENGTH_BIAS;
            r_cfg.length_limit <= RST_LENGTH_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_START_SYNC_A: r_cfg.start_sync_a <= i_cfg_data;
                CFG_START_SYNC_B: r_cfg.start_sync_b <= i_cfg_data;
                CFG_END_SYNC_B:   r_cfg.end_sync_b   <= i_cfg_data;
                CFG_MARKER_VALUE: r_cfg.marker_value <= i_cfg_data;
                CFG_LENGTH_BIAS:  r_cfg.length_bias  <= i_cfg_data;
                CFG_LENGTH_LIMIT: r_cfg.length_limit <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* rtl/scp_walker.sv */
// Frame walker: phase register, running checksum and per-byte result logic.
// Depends on scp_pkg.
module scp_walker
    import scp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    input  t_cfg       i_cfg,
    output t_result    o_result
);

    t_phase     r_phase, n_phase;
    logic [8:0] r_position, n_position;
    logic [7:0] r_body_left, n_body_left;
    logic [15:0] r_sum_acc, n_sum_acc;
    logic [7:0] r_check_high, n_check_high;
    logic       r_check_second, n_check_second;
    logic [7:0] r_cmd_a, n_cmd_a;
    logic [7:0] r_cmd_b, n_cmd_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_SYNC_A;
            r_position     <= '0;
            r_body_left    <= '0;
            r_sum_acc      <= '0;
            r_check_high   <= '0;
            r_check_second <= 1'b0;
            r_cmd_a        <= '0;
            r_cmd_b        <= '0;
        end else if (i_accept) begin
            r_phase        <= n_phase;
            r_position     <= n_position;
            r_body_left    <= n_body_left;
            r_sum_acc      <= n_sum_acc;
            r_check_high   <= n_check_high;
            r_check_second <= n_check_second;
            r_cmd_a        <= n_cmd_a;
            r_cmd_b        <= n_cmd_b;
        end
    end

    always_comb begin
        logic [8:0] pos_inc;
        logic [15:0] sum_add;
        logic [7:0] body_dec;
        logic       go_idle;

        pos_inc  = r_position + 9'd1;
        sum_add  = r_sum_acc + {8'd0, i_rx_byte};
        body_dec = (r_body_left != 8'd0) ? r_body_left - 8'd1 : r_body_left;
        go_idle  = 1'b0;

        n_phase        = r_phase;
        n_position     = r_position;
        n_body_left    = r_body_left;
        n_sum_acc      = r_sum_acc;
        n_check_high   = r_check_high;
        n_check_second = r_check_second;
        n_cmd_a        = r_cmd_a;
        n_cmd_b        = r_cmd_b;

        o_result.event_res    = EV_NONE;
        o_result.byte_value   = i_rx_byte;
        o_result.command_a    = '0;
        o_result.command_b    = '0;
        o_result.frame_length = '0;

        case (r_phase)
            PH_SYNC_A: begin
                if (i_rx_byte == i_cfg.start_sync_a) begin
                    n_position = pos_inc;
                    n_phase    = PH_SYNC_B;
                    o_result.event_res = EV_STORED;
                end
            end
            PH_SYNC_B: begin
                if (i_rx_byte == i_cfg.start_sync_b) begin
                    n_position = pos_inc;
                    n_phase    = PH_FLAG;
                    o_result.event_res = EV_STORED;
                end else begin
                    go_idle = 1'b1;
                    o_result.event_res = EV_HDR_BAD;
                end
            end
            PH_FLAG: begin
                n_position = pos_inc;
                n_sum_acc  = sum_add;
                n_phase    = PH_MARKER;
                o_result.event_res = EV_STORED;
            end
            PH_MARKER: begin
                if (i_rx_byte == i_cfg.marker_value) begin
                    n_position = pos_inc;
                    n_sum_acc  = sum_add;
                    n_phase    = PH_LEN;
                    o_result.event_res = EV_STORED;
                end else begin
                    go_idle = 1'b1;
                    o_result.event_res = EV_HDR_BAD;
                end
            end
            PH_LEN: begin
                if (i_rx_byte >= i_cfg.length_bias && i_rx_byte < i_cfg.length_limit) begin
                    n_position  = pos_inc;
                    n_sum_acc   = sum_add;
                    n_body_left = i_rx_byte - i_cfg.length_bias;
                    n_phase     = PH_HEADER;
                    o_result.event_res = EV_STORED;
                end else begin
                    go_idle = 1'b1;
                    o_result.event_res = EV_HDR_BAD;
                end
            end
            PH_HEADER: begin
                if (r_position == CMD_A_POS) n_cmd_a = i_rx_byte;
                if (r_position == CMD_B_POS) n_cmd_b = i_rx_byte;
                if (r_position >= HEADER_LAST_POS)
                    n_phase = (r_body_left == 8'd0) ? PH_CHECK : PH_BODY;
                n_position = pos_inc;
                n_sum_acc  = sum_add;
                o_result.event_res = EV_STORED;
            end
            PH_BODY: begin
                n_position  = pos_inc;
                n_sum_acc   = sum_add;
                n_body_left = body_dec;
                if (body_dec == 8'd0) n_phase = PH_CHECK;
                o_result.event_res = EV_STORED;
            end
            PH_CHECK: begin
                if (!r_check_second) begin
                    n_check_high   = i_rx_byte;
                    n_check_second = 1'b1;
                    n_position     = pos_inc;
                    o_result.event_res = EV_STORED;
                end else if (r_check_high == r_sum_acc[15:8] &&
                             i_rx_byte == r_sum_acc[7:0]) begin
                    n_check_second = 1'b0;
                    n_position     = pos_inc;
                    n_phase        = PH_END_A;
                    o_result.event_res = EV_STORED;
                end else begin
                    go_idle = 1'b1;
                    o_result.event_res = EV_SUM_BAD;
                end
            end
            PH_END_A: begin
                // a stray byte here is skipped and the wait goes on
                if (i_rx_byte == i_cfg.start_sync_a) begin
                    n_position = pos_inc;
                    n_phase    = PH_END_B;
                    o_result.event_res = EV_STORED;
                end
            end
            PH_END_B: begin
                if (i_rx_byte == i_cfg.end_sync_b) begin
                    o_result.event_res    = EV_GOOD;
                    o_result.frame_length = pos_inc;
                    o_result.command_a    = r_cmd_a;
                    o_result.command_b    = r_cmd_b;
                end else begin
                    o_result.event_res = EV_END_BAD;
                end
                go_idle = 1'b1;
            end
            default: go_idle = 1'b1;
        endcase

        if (go_idle) begin
            n_phase        = PH_SYNC_A;
            n_position     = '0;
            n_body_left    = '0;
            n_sum_acc      = '0;
            n_check_high   = '0;
            n_check_second = 1'b0;
        end

        o_result.byte_position = (o_result.event_res == EV_STORED ||
                                  o_result.event_res == EV_GOOD) ? r_position : 9'd0;
    end

endmodule

/* rtl/scp_out_stage.sv */
// Result register with a skid entry behind it.
// Depends on scp_pkg.
module scp_out_stage
    import scp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_result o_result
);

    logic    r_out_valid;
    logic    r_skid_valid;
    t_result r_out;
    t_result r_skid;
    logic    take;

    assign take        = r_out_valid & i_out_ready;
    assign o_in_ready  = ~r_skid_valid;
    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (i_load) begin
            if (!r_out_valid || take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (take) begin
            r_out_valid  <= r_skid_valid;
            r_skid_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            if (!r_out_valid || take) r_out  <= i_result;
            else                      r_skid <= i_result;
        end else if (take && r_skid_valid) begin
            r_out <= r_skid;
        end
    end

endmodule

/* rtl/scp_checker.sv */
// Port-level assertion checker for the frame parser, bound to the top level.
// Depends on scp_pkg and sync_checksum_frame_parser_macros.svh.
`include "sync_checksum_frame_parser_macros.svh"

module scp_checker
    import scp_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_in_ready,
    input logic       o_out_valid,
    input logic       i_out_ready,
    input logic [2:0] o_event_res,
    input logic [7:0] o_byte_value,
    input logic [8:0] o_byte_position,
    input logic [7:0] o_command_a,
    input logic [7:0] o_command_b,
    input logic [8:0] o_frame_length
);

    // reset empties the output stages
    property p_rst_empty;
        !i_rst_n |=> !o_out_valid && o_in_ready;
    endproperty

    // backpressure only while a result is pending
    property p_ready_low;
        !o_in_ready |-> o_out_valid;
    endproperty

    // a stalled result holds
    property p_hold;
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_event_res)
            && $stable(o_byte_value) && $stable(o_byte_position);
    endproperty

    // frame summary fields only on a good frame
    property p_summary;
        o_out_valid && o_event_res != EV_GOOD |-> o_frame_length == 9'd0
            && o_command_a == 8'd0 && o_command_b == 8'd0;
    endproperty

    // position only reported for stored bytes and good frames
    property p_position;
        o_out_valid && o_event_res != EV_STORED && o_event_res != EV_GOOD
            |-> o_byte_position == 9'd0;
    endproperty

    `SCP_ASSERT_ALWAYS(a_rst_empty, i_clk, p_rst_empty, "output not empty after reset")

    `SCP_ASSERT(a_ready_low, i_clk, i_rst_n, p_ready_low, "input stalled, no result")

    `SCP_ASSERT(a_hold, i_clk, i_rst_n, p_hold, "stalled result changed")

    `SCP_ASSERT(a_summary, i_clk, i_rst_n, p_summary, "summary outside good frame")

    `SCP_ASSERT(a_position, i_clk, i_rst_n, p_position, "position on non-stored event")

endmodule

bind sync_checksum_frame_parser scp_checker u_scp_checker (.*);
